[hdl/sts_pkg.sv]
`default_nettype none

package sts_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Widths of the word fields.
  localparam int VAL_W = 32;
  localparam int OP_W  = 2;
  localparam int REM_W = 11;
  localparam int WIN_W = 16;
  localparam int ST_W  = 2;

  localparam logic [WIN_W-1:0] WIN_MAX = '1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_Q_RD,
    S_Q_SCAN,
    S_Q_SHIFT,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_M2,
    RD_IDX_P1,
    RD_IDX_P2,
    RD_ONE
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_RDATA,
    WR_VAL
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    set_full;
    logic    set_empty;
    logic    take_found;
    logic    take_first;
    logic    cap_first;
    logic    emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic cnt_gt1;
    logic idx_zero;
    logic idx_one;
    logic idx_p1_lt_cnt;
    logic idx_p2_lt_cnt;
    logic gt;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

[hdl/sts_dp.sv]
`default_nettype none

module sts_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sts_pkg::cmd_t                  cmd,
  output sts_pkg::dp_sts_t                    sts,
  input  wire logic [sts_pkg::OP_W-1:0]       opcode,
  input  wire logic signed [sts_pkg::VAL_W-1:0] value,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic                                won,
  output logic                                removed_valid,
  output logic signed [sts_pkg::VAL_W-1:0]    removed_value,
  output logic [sts_pkg::REM_W-1:0]           remaining,
  output logic [sts_pkg::WIN_W-1:0]           win_total,
  output logic [sts_pkg::ST_W-1:0]            status
);

  logic [sts_pkg::VAL_W-1:0] mem [sts_pkg::TABLE_DEPTH];
  logic [sts_pkg::VAL_W-1:0] rdata;

  logic [sts_pkg::CNT_W-1:0] count;
  logic [sts_pkg::CNT_W-1:0] count_next;
  logic [sts_pkg::WIN_W-1:0] wins;
  logic [sts_pkg::WIN_W-1:0] wins_next;
  logic [sts_pkg::CNT_W-1:0] idx;
  logic [sts_pkg::CNT_W-1:0] idx_next;

  logic [sts_pkg::OP_W-1:0]  op;
  logic [sts_pkg::VAL_W-1:0] val;
  logic [sts_pkg::VAL_W-1:0] first_val;
  logic                      res_won;
  logic                      res_rvalid;
  logic [sts_pkg::VAL_W-1:0] res_rval;
  logic [sts_pkg::ST_W-1:0]  res_status;

  logic [sts_pkg::CNT_W-1:0] rd_full;
  logic [sts_pkg::ADDR_W-1:0] rd_addr;
  logic                      wr_en;
  logic [sts_pkg::VAL_W-1:0] wr_data;
  logic [sts_pkg::CNT_W:0]   idx_p1;
  logic [sts_pkg::CNT_W:0]   idx_p2;

  always_comb begin
    unique case (cmd.idx_op)
      sts_pkg::IDX_HOLD: idx_next = idx;
      sts_pkg::IDX_CNT:  idx_next = count;
      sts_pkg::IDX_ZERO: idx_next = '0;
      sts_pkg::IDX_INC:  idx_next = idx + sts_pkg::CNT_W'(1);
      sts_pkg::IDX_DEC:  idx_next = idx - sts_pkg::CNT_W'(1);
      default:           idx_next = idx;
    endcase
  end

  always_comb begin
    unique case (cmd.rd_sel)
      sts_pkg::RD_IDX:    rd_full = idx;
      sts_pkg::RD_IDX_M1: rd_full = idx - sts_pkg::CNT_W'(1);
      sts_pkg::RD_IDX_M2: rd_full = idx - sts_pkg::CNT_W'(2);
      sts_pkg::RD_IDX_P1: rd_full = idx + sts_pkg::CNT_W'(1);
      sts_pkg::RD_IDX_P2: rd_full = idx + sts_pkg::CNT_W'(2);
      sts_pkg::RD_ONE:    rd_full = sts_pkg::CNT_W'(1);
      default:            rd_full = idx;
    endcase
  end

  assign rd_addr = rd_full[sts_pkg::ADDR_W-1:0];
  assign wr_en   = (cmd.wr_sel != sts_pkg::WR_NONE);
  assign wr_data = (cmd.wr_sel == sts_pkg::WR_VAL) ? val : rdata;

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx[sts_pkg::ADDR_W-1:0]] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  // Per-word working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= opcode;
      val        <= value;
      res_won    <= 1'b0;
      res_rvalid <= 1'b0;
      res_rval   <= '0;
      if (cmd.set_full) begin
        res_status <= sts_pkg::ST_FULL;
      end else if (cmd.set_empty) begin
        res_status <= sts_pkg::ST_EMPTY;
      end else begin
        res_status <= sts_pkg::ST_OK;
      end
    end
    if (cmd.cap_first && idx == '0) begin
      first_val <= rdata;
    end
    if (cmd.take_found) begin
      res_won    <= 1'b1;
      res_rvalid <= 1'b1;
      res_rval   <= rdata;
    end
    if (cmd.take_first) begin
      res_rvalid <= 1'b1;
      res_rval   <= (idx == '0) ? rdata : first_val;
    end
  end

  // Count and win total are committed when the result word is issued.
  always_comb begin
    count_next = count;
    wins_next  = wins;
    unique case (op)
      sts_pkg::OP_INSERT: begin
        if (res_status == sts_pkg::ST_OK) begin
          count_next = count + sts_pkg::CNT_W'(1);
        end
      end
      sts_pkg::OP_QUERY: begin
        if (res_rvalid) begin
          count_next = count - sts_pkg::CNT_W'(1);
        end
        if (res_won && wins != sts_pkg::WIN_MAX) begin
          wins_next = wins + sts_pkg::WIN_W'(1);
        end
      end
      sts_pkg::OP_CLEAR: begin
        count_next = '0;
        wins_next  = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      wins      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        count     <= count_next;
        wins      <= wins_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      won           <= res_won;
      removed_valid <= res_rvalid;
      removed_value <= res_rval;
      remaining     <= sts_pkg::REM_W'(count_next);
      win_total     <= wins_next;
      status        <= res_status;
    end
  end

  assign idx_p1 = {1'b0, idx} + (sts_pkg::CNT_W + 1)'(1);
  assign idx_p2 = {1'b0, idx} + (sts_pkg::CNT_W + 1)'(2);

  always_comb begin
    sts.cnt_zero      = (count == '0);
    sts.cnt_full      = ({1'b0, count} >= (sts_pkg::CNT_W + 1)'(sts_pkg::TABLE_DEPTH));
    sts.cnt_gt1       = (count > sts_pkg::CNT_W'(1));
    sts.idx_zero      = (idx == '0);
    sts.idx_one       = (idx == sts_pkg::CNT_W'(1));
    sts.idx_p1_lt_cnt = (idx_p1 < {1'b0, count});
    sts.idx_p2_lt_cnt = (idx_p2 < {1'b0, count});
    sts.gt            = ($signed(rdata) > $signed(val));
    sts.out_busy      = out_valid && out_stall;
  end

endmodule

`default_nettype wire

[hdl/sts_ctrl.sv]
`default_nettype none

module sts_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [sts_pkg::OP_W-1:0] opcode,
  input  wire sts_pkg::dp_sts_t         sts,
  output sts_pkg::cmd_t                 cmd
);

  sts_pkg::state_t state;
  sts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.idx_op     = sts_pkg::IDX_HOLD;
    cmd.rd_sel     = sts_pkg::RD_IDX;
    cmd.wr_sel     = sts_pkg::WR_NONE;
    unique case (state)
      sts_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (opcode == sts_pkg::OP_INSERT) begin
            if (sts.cnt_full) begin
              cmd.set_full = 1'b1;
              state_next   = sts_pkg::S_FIN;
            end else begin
              cmd.idx_op = sts_pkg::IDX_CNT;
              state_next = sts_pkg::S_INS_RD;
            end
          end else if (opcode == sts_pkg::OP_QUERY) begin
            if (sts.cnt_zero) begin
              cmd.set_empty = 1'b1;
              state_next    = sts_pkg::S_FIN;
            end else begin
              cmd.idx_op = sts_pkg::IDX_ZERO;
              state_next = sts_pkg::S_Q_RD;
            end
          end else begin
            state_next = sts_pkg::S_FIN;
          end
        end
      end
      sts_pkg::S_INS_RD: begin
        if (sts.idx_zero) begin
          cmd.wr_sel = sts_pkg::WR_VAL;
          state_next = sts_pkg::S_FIN;
        end else begin
          cmd.rd_sel = sts_pkg::RD_IDX_M1;
          state_next = sts_pkg::S_INS_CMP;
        end
      end
      sts_pkg::S_INS_CMP: begin
        if (sts.gt) begin
          cmd.wr_sel = sts_pkg::WR_RDATA;
          cmd.idx_op = sts_pkg::IDX_DEC;
          cmd.rd_sel = sts_pkg::RD_IDX_M2;
          if (sts.idx_one) begin
            state_next = sts_pkg::S_INS_PUT;
          end
        end else begin
          cmd.wr_sel = sts_pkg::WR_VAL;
          state_next = sts_pkg::S_FIN;
        end
      end
      sts_pkg::S_INS_PUT: begin
        cmd.wr_sel = sts_pkg::WR_VAL;
        state_next = sts_pkg::S_FIN;
      end
      sts_pkg::S_Q_RD: begin
        cmd.rd_sel = sts_pkg::RD_IDX;
        state_next = sts_pkg::S_Q_SCAN;
      end
      sts_pkg::S_Q_SCAN: begin
        cmd.cap_first = 1'b1;
        priority if (sts.gt) begin
          cmd.take_found = 1'b1;
          cmd.rd_sel     = sts_pkg::RD_IDX_P1;
          state_next     = sts.idx_p1_lt_cnt ? sts_pkg::S_Q_SHIFT : sts_pkg::S_FIN;
        end else if (sts.idx_p1_lt_cnt) begin
          cmd.idx_op = sts_pkg::IDX_INC;
          cmd.rd_sel = sts_pkg::RD_IDX_P1;
        end else begin
          // Nothing beats the query: the smallest entry goes instead.
          cmd.take_first = 1'b1;
          cmd.idx_op     = sts_pkg::IDX_ZERO;
          cmd.rd_sel     = sts_pkg::RD_ONE;
          state_next     = sts.cnt_gt1 ? sts_pkg::S_Q_SHIFT : sts_pkg::S_FIN;
        end
      end
      sts_pkg::S_Q_SHIFT: begin
        cmd.wr_sel = sts_pkg::WR_RDATA;
        cmd.idx_op = sts_pkg::IDX_INC;
        cmd.rd_sel = sts_pkg::RD_IDX_P2;
        if (!sts.idx_p2_lt_cnt) begin
          state_next = sts_pkg::S_FIN;
        end
      end
      sts_pkg::S_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = sts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sts_pkg::S_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_busy)
    else $error("result issued while output register still held");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken before the first finished");

  a_ins_cmp_idx: assert property (@(posedge clk) disable iff (rst)
    (state == sts_pkg::S_INS_CMP) |-> !sts.idx_zero)
    else $error("insert shift ran below entry zero");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == sts_pkg::S_Q_SHIFT) |-> sts.idx_p1_lt_cnt)
    else $error("removal shift read past the last entry");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_sel != sts_pkg::WR_NONE) |-> (state != sts_pkg::S_IDLE && state != sts_pkg::S_FIN))
    else $error("table written outside an operation");

endmodule

`default_nettype wire

[hdl/sorted_table_successor_remove.sv]
// Throughput: one word at a time; the table, with one write port and one registered read
// port, is scanned and shifted one entry per cycle.
// Reset: synchronous and active high; the table empties and the win total clears at once,
// with no clearing pass, since entries at or above the count are never used.
`default_nettype none

module sorted_table_successor_remove (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [sts_pkg::OP_W-1:0]         opcode,
  input  wire logic signed [sts_pkg::VAL_W-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  won,
  output logic                                  removed_valid,
  output logic signed [sts_pkg::VAL_W-1:0]      removed_value,
  output logic [sts_pkg::REM_W-1:0]             remaining,
  output logic [sts_pkg::WIN_W-1:0]             win_total,
  output logic [sts_pkg::ST_W-1:0]              status
);

  // The controller sequences each word through the table; the datapath holds the
  // table memory, the count, the win total and the output register. A finished
  // result sits in the output register while the controller takes the next word,
  // so a stalled consumer only holds up the block when a second result is ready.
  sts_pkg::cmd_t    cmd;
  sts_pkg::dp_sts_t sts;

  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Inserts walk down from the top entry, moving larger values up one place
  // until the new value fits. Queries walk up from entry zero to the first value
  // that beats it, else entry zero, then pull the rest of the table down over the hole.
  sts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .value         (value),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .won           (won),
    .removed_valid (removed_valid),
    .removed_value (removed_value),
    .remaining     (remaining),
    .win_total     (win_total),
    .status        (status)
  );

endmodule

`default_nettype wire
